// ===== hdl/rpfh_pkg.sv =====
// Shared types and constants for the ray/polygon farthest-hit block.
// Used by rpfh_ctrl, rpfh_datapath and ray_polygon_farthest_hit; depends on nothing.
package rpfh_pkg;

	// Distance result width and its saturation value.
	localparam int DIST_BITS = 20;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y = 1'b1;

	// Sequencer lengths: six products plus one drain step, one divider step per bit.
	localparam int MUL_STEPS = 7;
	localparam int DIV_STEPS = DIST_BITS;
	localparam int CNT_BITS  = 5;

	// Product order on the shared multiplier.
	localparam logic [2:0] P_EX_DY = 3'd0;
	localparam logic [2:0] P_EY_DX = 3'd1;
	localparam logic [2:0] P_EX_RY = 3'd2;
	localparam logic [2:0] P_EY_RX = 3'd3;
	localparam logic [2:0] P_DX_RY = 3'd4;
	localparam logic [2:0] P_DY_RX = 3'd5;

	// Difference targets, one per pair of products.
	localparam logic [1:0] T_DEN = 2'd0;
	localparam logic [1:0] T_NT  = 2'd1;
	localparam logic [1:0] T_NS  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_NORM,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       mul;
		logic [2:0] mul_step;
		logic       norm;
		logic       check;
		logic       div;
		logic       update;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic hit;
		logic sat;
		logic out_free;
	} status_t;

endpackage

// ===== hdl/rpfh_ctrl.sv =====
// Sequencing state machine for the ray/polygon farthest-hit block.
// Depends on rpfh_pkg; drives rpfh_datapath through cmd_t and reads status_t.
module rpfh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rpfh_pkg::status_t status,
	output rpfh_pkg::cmd_t    cmd
);

	rpfh_pkg::state_t state_q, state_d;
	logic [rpfh_pkg::CNT_BITS-1:0] cnt_q;

	logic mul_done;
	logic div_done;

	assign mul_done = (cnt_q == rpfh_pkg::CNT_BITS'(rpfh_pkg::MUL_STEPS - 1));
	assign div_done = (cnt_q == rpfh_pkg::CNT_BITS'(rpfh_pkg::DIV_STEPS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rpfh_pkg::ST_IDLE: begin
				if (in_valid) state_d = rpfh_pkg::ST_MUL;
			end
			rpfh_pkg::ST_MUL: begin
				if (mul_done) state_d = rpfh_pkg::ST_NORM;
			end
			rpfh_pkg::ST_NORM: begin
				state_d = rpfh_pkg::ST_CHECK;
			end
			rpfh_pkg::ST_CHECK: begin
				priority if (!status.hit) begin
					state_d = status.last ? rpfh_pkg::ST_UPDATE : rpfh_pkg::ST_IDLE;
				end else if (status.sat) begin
					state_d = rpfh_pkg::ST_UPDATE;
				end else begin
					state_d = rpfh_pkg::ST_DIV;
				end
			end
			rpfh_pkg::ST_DIV: begin
				if (div_done) state_d = rpfh_pkg::ST_UPDATE;
			end
			rpfh_pkg::ST_UPDATE: begin
				if (!status.last || status.out_free) state_d = rpfh_pkg::ST_IDLE;
			end
			default: state_d = rpfh_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == rpfh_pkg::ST_IDLE);
		cmd.capture  = in_ready && in_valid;
		cmd.mul      = (state_q == rpfh_pkg::ST_MUL);
		cmd.mul_step = cnt_q[2:0];
		cmd.norm     = (state_q == rpfh_pkg::ST_NORM);
		cmd.check    = (state_q == rpfh_pkg::ST_CHECK);
		cmd.div      = (state_q == rpfh_pkg::ST_DIV);
		cmd.update   = (state_q == rpfh_pkg::ST_UPDATE) && (!status.last || status.out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpfh_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == rpfh_pkg::ST_MUL || state_q == rpfh_pkg::ST_DIV) && state_d == state_q)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

endmodule

// ===== hdl/rpfh_datapath.sv =====
// Datapath of the ray/polygon farthest-hit block: shared multiplier, sign
// normalization, hit test, restoring divider and best-distance tracking.
// Depends on rpfh_pkg; sequenced by rpfh_ctrl.
module rpfh_datapath #(
	parameter int COORD_BITS    = 16,
	parameter int DIR_FRAC_BITS = 14
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rpfh_pkg::cmd_t                       cmd,
	output rpfh_pkg::status_t                    status,
	input  logic                                 cfg_we,
	input  logic [rpfh_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0]                cfg_data,
	input  logic [COORD_BITS-1:0]                start_x,
	input  logic [COORD_BITS-1:0]                start_y,
	input  logic [COORD_BITS-1:0]                end_x,
	input  logic [COORD_BITS-1:0]                end_y,
	input  logic signed [DIR_FRAC_BITS+1:0]      dir_x,
	input  logic signed [DIR_FRAC_BITS+1:0]      dir_y,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 hit,
	output logic [rpfh_pkg::DIST_BITS-1:0]       distance
);

	localparam int DW   = DIR_FRAC_BITS + 2;
	localparam int OW   = COORD_BITS + 1;
	localparam int MW   = (OW > DW) ? OW : DW;
	localparam int PW   = 2 * MW;
	localparam int DENW = COORD_BITS + DW + 1;
	localparam int NTW  = 2 * COORD_BITS + 2;
	localparam int NB   = NTW - 1 + DIR_FRAC_BITS;
	localparam int QB   = rpfh_pkg::DIST_BITS;
	localparam int HW   = NB - QB;
	localparam int CW   = (HW > DENW) ? HW : DENW;

	logic [COORD_BITS-1:0] cx_q, cy_q;

	logic signed [OW-1:0] ex_q, ey_q, rx_q, ry_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic                 last_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q, acc_q;
	logic signed [PW:0]   pair_diff;
	logic [2:0]           prev_step;

	logic signed [DENW-1:0] den_q, ns_q;
	logic signed [NTW-1:0]  nt_q;

	logic [DENW-2:0] den_mag;
	logic [NB-1:0]   num;
	logic [HW-1:0]   num_hi;
	logic            hit_c, sat_c;
	logic            hit_q;

	logic [DENW-1:0] rem_q;
	logic [QB-1:0]   quo_q;
	logic [DENW:0]   trial, trial_diff, den_ext;
	logic            trial_ge;

	logic [QB-1:0] best_q, best_new;
	logic          any_q, any_new;

	logic          out_valid_q, out_hit_q;
	logic [QB-1:0] out_dist_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rpfh_pkg::REG_CENTER_X: cx_q <= cfg_data;
				rpfh_pkg::REG_CENTER_Y: cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Edge vector and origin offset are formed as the request is taken.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ex_q   <= signed'({1'b0, end_x} - {1'b0, start_x});
			ey_q   <= signed'({1'b0, end_y} - {1'b0, start_y});
			rx_q   <= signed'({1'b0, start_x} - {1'b0, cx_q});
			ry_q   <= signed'({1'b0, start_y} - {1'b0, cy_q});
			dx_q   <= dir_x;
			dy_q   <= dir_y;
			last_q <= last;
		end
	end

	always_comb begin
		unique case (cmd.mul_step)
			rpfh_pkg::P_EX_DY: begin mul_a = MW'(ex_q); mul_b = MW'(dy_q); end
			rpfh_pkg::P_EY_DX: begin mul_a = MW'(ey_q); mul_b = MW'(dx_q); end
			rpfh_pkg::P_EX_RY: begin mul_a = MW'(ex_q); mul_b = MW'(ry_q); end
			rpfh_pkg::P_EY_RX: begin mul_a = MW'(ey_q); mul_b = MW'(rx_q); end
			rpfh_pkg::P_DX_RY: begin mul_a = MW'(dx_q); mul_b = MW'(ry_q); end
			rpfh_pkg::P_DY_RX: begin mul_a = MW'(dy_q); mul_b = MW'(rx_q); end
			default:           begin mul_a = '0;        mul_b = '0;        end
		endcase
	end

	assign prev_step = cmd.mul_step - 3'd1;
	assign pair_diff = (PW+1)'(acc_q) - (PW+1)'(prod_q);

	// Hit test on the normalized terms; den_q is non-negative here.
	assign den_mag = den_q[DENW-2:0];
	assign num     = {nt_q[NTW-2:0], {DIR_FRAC_BITS{1'b0}}};
	assign num_hi  = num[NB-1:QB];
	assign hit_c   = (den_q != '0) && !nt_q[NTW-1] && !ns_q[DENW-1] && (ns_q <= den_q);
	assign sat_c   = (CW'(num_hi) >= CW'(den_mag));

	// One restoring step: the next numerator bit enters from the top of quo_q.
	assign trial      = {rem_q, quo_q[QB-1]};
	assign den_ext    = (DENW+1)'(den_mag);
	assign trial_ge   = (trial >= den_ext);
	assign trial_diff = trial - den_ext;

	assign any_new  = any_q | hit_q;
	assign best_new = (hit_q && (!any_q || quo_q > best_q)) ? quo_q : best_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= PW'(mul_a) * PW'(mul_b);
			if (cmd.mul_step != 3'd0) begin
				if (!prev_step[0]) begin
					acc_q <= prod_q;
				end else begin
					unique case (prev_step[2:1])
						rpfh_pkg::T_DEN: den_q <= pair_diff[DENW-1:0];
						rpfh_pkg::T_NT:  nt_q  <= pair_diff[NTW-1:0];
						rpfh_pkg::T_NS:  ns_q  <= pair_diff[DENW-1:0];
						default: ;
					endcase
				end
			end
		end
		if (cmd.norm && den_q[DENW-1]) begin
			den_q <= -den_q;
			nt_q  <= -nt_q;
			ns_q  <= -ns_q;
		end
		if (cmd.check) begin
			hit_q <= hit_c;
			if (sat_c) begin
				quo_q <= rpfh_pkg::DIST_MAX;
			end else begin
				rem_q <= DENW'(num_hi);
				quo_q <= num[QB-1:0];
			end
		end
		if (cmd.div) begin
			rem_q <= trial_ge ? trial_diff[DENW-1:0] : trial[DENW-1:0];
			quo_q <= {quo_q[QB-2:0], trial_ge};
		end
		if (cmd.update && last_q) begin
			out_hit_q  <= any_new;
			out_dist_q <= any_new ? best_new : '0;
		end
	end

	// A miss on a last edge goes from the check step straight to the update step;
	// hit_q is not stale there, since the check step always rewrites it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				if (last_q) begin
					best_q <= '0;
					any_q  <= 1'b0;
				end else begin
					best_q <= best_new;
					any_q  <= any_new;
				end
			end
			if (cmd.update && last_q)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign status.last     = last_q;
	assign status.hit      = hit_c;
	assign status.sat      = sat_c;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign hit       = out_hit_q;
	assign distance  = out_dist_q;

	a_norm_positive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.norm |=> !den_q[DENW-1])
		else $error("denominator negative after normalization");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div |-> (rem_q < DENW'(den_mag)))
		else $error("divider remainder not below denominator");

	a_best_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!any_q |-> (best_q == '0))
		else $error("best distance held without any hit");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_hit_q) |-> (out_dist_q == '0))
		else $error("no-hit result carries a distance");

endmodule

// ===== hdl/ray_polygon_farthest_hit.sv =====
// Top level of the ray/polygon farthest-hit block.
// Depends on rpfh_pkg, rpfh_ctrl and rpfh_datapath.
//
// The block casts a ray from the configured center (center_x, center_y) along
// the Q1.14-style direction (dir_x, dir_y) and tests it against one polygon edge
// per input request. An edge counts when it is not parallel to the ray, the ray
// parameter is non-negative and the crossing lies on the edge, ends included.
// The distance is floor(num_t * 2^DIR_FRAC_BITS / denom) in 1/16 pixel units,
// saturated at 2^20-1, and the block keeps the farthest one. The request
// flagged last closes the query: it is counted, then one output request with
// hit and distance is issued (distance 0 when nothing was hit) and the running
// state is cleared. Edges are handled one at a time. A request is taken only in
// the idle state, and a taken edge passes through a capture step, six cross
// products formed on a single shared multiplier, a sign normalization step, a
// hit test, twenty steps of a restoring divider (one quotient bit per cycle)
// and an update step. A miss that is not the last edge returns to idle after
// the hit test, and a saturated distance or a missed last edge skips the
// divider. The result sits in an output register, so the next edge is taken
// while a result waits for out_ready; only a further last edge waits for the
// register to free up.
module ray_polygon_farthest_hit #(
	parameter int COORD_BITS    = 16,
	parameter int DIR_FRAC_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rpfh_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [COORD_BITS-1:0]               start_x,
	input  logic [COORD_BITS-1:0]               start_y,
	input  logic [COORD_BITS-1:0]               end_x,
	input  logic [COORD_BITS-1:0]               end_y,
	input  logic signed [DIR_FRAC_BITS+1:0]     dir_x,
	input  logic signed [DIR_FRAC_BITS+1:0]     dir_y,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic [rpfh_pkg::DIST_BITS-1:0]      distance
);

	// Commands from the sequencer and status back from the datapath.
	rpfh_pkg::cmd_t    cmd;
	rpfh_pkg::status_t status;

	rpfh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rpfh_datapath #(
		.COORD_BITS    (COORD_BITS),
		.DIR_FRAC_BITS (DIR_FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.distance  (distance)
	);

endmodule
